// ===== hdl/ins_pkg.sv =====
package ins_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_EMIT_RD,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic final_word;
        logic dropped;
    } emit_flags_t;

endpackage

// ===== hdl/ins_ram.sv =====
module ins_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ins_core.sv =====
module ins_core #(
    parameter int MAX_ITEMS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [DATA_WIDTH-1:0]        in_value,
    input  logic                         in_last,
    output logic                         ram_wr_en,
    output logic [$clog2(MAX_ITEMS)-1:0] ram_wr_addr,
    output logic [DATA_WIDTH-1:0]        ram_wr_data,
    output logic [$clog2(MAX_ITEMS)-1:0] ram_rd_addr,
    input  logic [DATA_WIDTH-1:0]        ram_rd_data,
    output logic                         emit_valid,
    input  logic                         emit_ready,
    output logic [DATA_WIDTH-1:0]        emit_value,
    output ins_pkg::emit_flags_t         emit_flags
);

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

    ins_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic                  ovf_reg, ovf_next;
    logic [ADDR_W-1:0]     pos_reg, pos_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic                  last_reg, last_next;

    logic              full;
    logic              empty;
    logic              less;
    logic              is_final;
    logic [ADDR_W-1:0] pos_m1;

    assign full     = (fill_reg == CNT_W'(MAX_ITEMS));
    assign empty    = (fill_reg == '0);
    assign less     = ($signed(val_reg) < $signed(ram_rd_data));
    assign pos_m1   = pos_reg - ADDR_W'(1);
    assign is_final = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ins_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (full || empty) begin
                        state_next = in_last ? ins_pkg::ST_EMIT_RD : ins_pkg::ST_IDLE;
                    end else begin
                        state_next = ins_pkg::ST_SHIFT;
                    end
                end
            end
            ins_pkg::ST_SHIFT: begin
                if (less) begin
                    state_next = (pos_m1 == '0) ? ins_pkg::ST_PLACE : ins_pkg::ST_SHIFT;
                end else begin
                    state_next = last_reg ? ins_pkg::ST_EMIT_RD : ins_pkg::ST_IDLE;
                end
            end
            ins_pkg::ST_PLACE: begin
                state_next = last_reg ? ins_pkg::ST_EMIT_RD : ins_pkg::ST_IDLE;
            end
            ins_pkg::ST_EMIT_RD: begin
                state_next = ins_pkg::ST_LOAD;
            end
            ins_pkg::ST_LOAD: begin
                if (emit_ready) begin
                    state_next = is_final ? ins_pkg::ST_IDLE : ins_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ins_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        emit_valid  = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = pos_reg;
        ram_wr_data = val_reg;
        ram_rd_addr = idx_reg;
        case (state_reg)
            ins_pkg::ST_IDLE: begin
                in_ready    = 1'b1;
                ram_rd_addr = ADDR_W'(fill_reg - CNT_W'(1));
                ram_wr_addr = '0;
                ram_wr_data = in_value;
                ram_wr_en   = in_valid && empty;
            end
            ins_pkg::ST_SHIFT: begin
                ram_wr_en = 1'b1;
                if (less) begin
                    ram_wr_data = ram_rd_data;
                    ram_rd_addr = pos_m1 - ADDR_W'(1);
                end
            end
            ins_pkg::ST_PLACE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
            end
            ins_pkg::ST_EMIT_RD: begin
                ram_rd_addr = idx_reg;
            end
            ins_pkg::ST_LOAD: begin
                emit_valid = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        pos_next  = pos_reg;
        idx_next  = idx_reg;
        val_next  = val_reg;
        last_next = last_reg;
        case (state_reg)
            ins_pkg::ST_IDLE: begin
                idx_next = '0;
                if (in_valid) begin
                    val_next  = in_value;
                    last_next = in_last;
                    pos_next  = ADDR_W'(fill_reg);
                    if (full) begin
                        ovf_next = 1'b1;
                    end else if (empty) begin
                        fill_next = CNT_W'(1);
                    end
                end
            end
            ins_pkg::ST_SHIFT: begin
                if (less) begin
                    pos_next = pos_m1;
                end else begin
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            ins_pkg::ST_PLACE: begin
                fill_next = fill_reg + CNT_W'(1);
            end
            ins_pkg::ST_LOAD: begin
                if (emit_ready) begin
                    idx_next = idx_reg + ADDR_W'(1);
                    if (is_final) begin
                        fill_next = '0;
                        ovf_next  = 1'b0;
                    end
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ins_pkg::ST_IDLE;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        last_reg <= last_next;
    end

    assign emit_value            = ram_rd_data;
    assign emit_flags.final_word = is_final;
    assign emit_flags.dropped    = ovf_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ins_pkg::ST_SHIFT |-> pos_reg != '0)
        else $error("shift step at bottom of store");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_valid |-> !empty && CNT_W'(idx_reg) < fill_reg)
        else $error("emit beyond stored run");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_valid && emit_ready && is_final |=> empty && !ovf_reg)
        else $error("store not cleared after final word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready && full |=> ovf_reg)
        else $error("overflow not recorded");
`endif

endmodule

// ===== hdl/insertion_sorter.sv =====
// Insertion sorter. Takes a batch of signed DATA_WIDTH-bit words, one per accepted
// s_ word, and keeps them in ascending order in a MAX_ITEMS-deep RAM; equal values
// keep their arrival order. The word with s_tlast set closes the batch: the whole
// batch then leaves on m_ in ascending order, m_tlast on the greatest, m_tuser set
// on every word if values past capacity were dropped in that batch. A word sent to an
// empty store is written straight in and one sent to a full store is dropped; otherwise
// each stored entry greater than it moves up one place: one comparator and the RAM's
// single write port move one entry per cycle. Each result passes through the registered
// RAM read, then the output register. s_tready is low while a word is inserted or a
// batch is sent out; the output register lets the next batch start while the last
// word still waits for m_tready.
module insertion_sorter #(
    parameter int MAX_ITEMS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // sample_value, zero pad
    input  logic                                 s_tlast,  // batch_end
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata,  // sorted_value, zero pad
    output logic                                 m_tlast,  // final_result
    output logic                                 m_tuser   // dropped_flag
);

    localparam int ADDR_W  = $clog2(MAX_ITEMS);
    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    logic                  emit_valid;
    logic                  emit_ready;
    logic [DATA_WIDTH-1:0] emit_value;
    ins_pkg::emit_flags_t  emit_flags;

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic                  out_last_reg;
    logic                  out_user_reg;

    ins_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_ITEMS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ins_core #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_value    (s_tdata[DATA_WIDTH-1:0]),
        .in_last     (s_tlast),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .emit_valid  (emit_valid),
        .emit_ready  (emit_ready),
        .emit_value  (emit_value),
        .emit_flags  (emit_flags)
    );

    assign emit_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit_valid && emit_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_valid && emit_ready) begin
            out_data_reg <= emit_value;
            out_last_reg <= emit_flags.final_word;
            out_user_reg <= emit_flags.dropped;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== verif/sort_checker.sv =====
`timescale 1ns / 100ps

module sort_checker #(
    parameter int MAX_ITEMS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // sample_value, zero pad
    input  logic                                  s_tlast,  // batch_end
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata,  // sorted_value, zero pad
    input  logic                                  m_tlast,  // final_result
    input  logic                                  m_tuser,  // dropped_flag
    output int                                    fail_count,
    output int                                    words_pending
);

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  final_word;
        logic                  dropped;
    } sorted_word_t;

    logic signed [DATA_WIDTH-1:0] sort_store [MAX_ITEMS];
    int                           fill_count;
    bit                           overflow_seen;
    sorted_word_t                 sorted_queue [$];

    task automatic insert_sample(input logic signed [DATA_WIDTH-1:0] v, input logic batch_end);
        int           pos;
        sorted_word_t w;
        if (fill_count >= MAX_ITEMS) begin
            overflow_seen = 1'b1;
        end else begin
            pos = fill_count;
            // shift strictly greater entries up; equal ones keep arrival order
            while (pos > 0 && v < sort_store[pos-1]) begin
                sort_store[pos] = sort_store[pos-1];
                pos--;
            end
            sort_store[pos] = v;
            fill_count++;
        end
        if (batch_end) begin
            for (int k = 0; k < fill_count; k++) begin
                w.value      = sort_store[k];
                w.final_word = (k == fill_count - 1);
                w.dropped    = overflow_seen;
                sorted_queue.push_back(w);
            end
            fill_count    = 0;
            overflow_seen = 1'b0;
        end
    endtask

    task automatic check_word();
        sorted_word_t w;
        if (sorted_queue.size() == 0) begin
            $error("unexpected word: sorted_value %0d", $signed(m_tdata[DATA_WIDTH-1:0]));
            fail_count++;
        end else begin
            w = sorted_queue.pop_front();
            if (m_tdata[DATA_WIDTH-1:0] !== w.value) begin
                $error("sorted_value: expected %0d, got %0d", $signed(w.value),
                       $signed(m_tdata[DATA_WIDTH-1:0]));
                fail_count++;
            end
            if (m_tlast !== w.final_word) begin
                $error("final_result: expected %0b, got %0b", w.final_word, m_tlast);
                fail_count++;
            end
            if (m_tuser !== w.dropped) begin
                $error("dropped_flag: expected %0b, got %0b", w.dropped, m_tuser);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill_count    = 0;
            overflow_seen = 1'b0;
            fail_count    = 0;
            sorted_queue.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_word();
            end
            if (s_tvalid && s_tready) begin
                insert_sample(s_tdata[DATA_WIDTH-1:0], s_tlast);
            end
        end
        words_pending = sorted_queue.size();
    end

endmodule

// ===== verif/tb_insertion_sorter.sv =====
`timescale 1ns / 100ps

module tb_insertion_sorter;

    localparam int MAX_ITEMS   = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int TW          = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int WORD_TARGET = 470;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [TW-1:0] s_tdata;   // sample_value, zero pad
    logic          s_tlast;   // batch_end
    logic          m_tvalid;
    logic          m_tready;
    logic [TW-1:0] m_tdata;   // sorted_value, zero pad
    logic          m_tlast;   // final_result
    logic          m_tuser;   // dropped_flag

    int fail_count;
    int words_pending;
    int tx_idle_pct;
    int rx_idle_pct;
    int words_sent;
    int cycle_count;
    int hold_left;
    bit hold_used;
    int phase;
    int batch_len;

    insertion_sorter #(
        .MAX_ITEMS (MAX_ITEMS),
        .DATA_WIDTH(DATA_WIDTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    sort_checker #(
        .MAX_ITEMS (MAX_ITEMS),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .words_pending(words_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("insertion_sorter verification failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_used && words_sent >= 60) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        logic [DATA_WIDTH-1:0] v;
        case ($urandom_range(9))
            5, 6: v = DATA_WIDTH'($signed($urandom_range(8)) - 4);
            7: v = {1'b0, {(DATA_WIDTH - 1){1'b1}}} - DATA_WIDTH'($urandom_range(2));
            8: v = {1'b1, {(DATA_WIDTH - 1){1'b0}}} + DATA_WIDTH'($urandom_range(2));
            9: v = {DATA_WIDTH{$urandom_range(1) == 1}};
            default: v = DATA_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    // called and returns at a falling edge
    task automatic send_word(input logic [DATA_WIDTH-1:0] v, input logic batch_end);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TW'(v);
        s_tlast  <= batch_end;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (words_pending != 0) @(negedge aclk);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        tx_idle_pct = 30;
        rx_idle_pct = 60;
        words_sent  = 0;
        cycle_count = 0;
        phase       = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // extremes, negatives and duplicates in one batch
        send_word({1'b0, {(DATA_WIDTH - 1){1'b1}}}, 1'b0);
        send_word({1'b1, {(DATA_WIDTH - 1){1'b0}}}, 1'b0);
        send_word('0, 1'b0);
        send_word('1, 1'b0);
        send_word(DATA_WIDTH'(5), 1'b0);
        send_word(DATA_WIDTH'(5), 1'b0);
        send_word('1, 1'b1);
        // single-word batch
        send_word(DATA_WIDTH'(32'h1234_5678), 1'b1);
        // descending fill to capacity, closing word dropped on a full store
        for (int i = 0; i < MAX_ITEMS; i++) begin
            send_word(DATA_WIDTH'(32'h7fff_fff0 - 32'(i) * 32'h0100_0000), 1'b0);
        end
        send_word({1'b1, {(DATA_WIDTH - 1){1'b0}}}, 1'b1);
        drain_results();

        while (words_sent < WORD_TARGET) begin
            if (phase == 0 && words_sent >= 190) begin
                drain_results();
                tx_idle_pct = 60;
                rx_idle_pct = 30;
                phase       = 1;
            end else if (phase == 1 && words_sent >= 350) begin
                drain_results();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                phase       = 2;
            end
            if ($urandom_range(9) == 0) begin
                batch_len = $urandom_range(MAX_ITEMS + 6, MAX_ITEMS + 1);
            end else if ($urandom_range(7) == 0) begin
                batch_len = MAX_ITEMS;
            end else begin
                batch_len = $urandom_range(MAX_ITEMS, 1);
            end
            for (int i = 0; i < batch_len; i++) begin
                send_word(pick_value(), i == batch_len - 1);
            end
        end
        s_tvalid <= 1'b0;

        drain_results();
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("insertion_sorter verification clean");
        end else begin
            $display("insertion_sorter verification failed");
        end
        $finish;
    end

endmodule
